// File: hw/rtl/lls_pkg.sv
// Shared types, constants and the brightness step map for the light level stabilizer.
`timescale 1ns / 1ps

package lls_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int LEVEL_BITS  = 7;
   localparam int COUNT_BITS  = 8;
   // widest intermediate of 7*filtered + sample
   localparam int ACC_BITS    = SAMPLE_BITS + 3;

   localparam logic [COUNT_BITS-1:0] STABLE_COUNT_RESET = COUNT_BITS'(3);

   typedef enum logic {
      ACTION_INIT   = 1'b0,
      ACTION_UPDATE = 1'b1
   } action_type;

   localparam logic [SAMPLE_BITS-1:0] THRESH_0 = SAMPLE_BITS'(200);
   localparam logic [SAMPLE_BITS-1:0] THRESH_1 = SAMPLE_BITS'(500);
   localparam logic [SAMPLE_BITS-1:0] THRESH_2 = SAMPLE_BITS'(1000);
   localparam logic [SAMPLE_BITS-1:0] THRESH_3 = SAMPLE_BITS'(1800);
   localparam logic [SAMPLE_BITS-1:0] THRESH_4 = SAMPLE_BITS'(2600);
   localparam logic [SAMPLE_BITS-1:0] THRESH_5 = SAMPLE_BITS'(3200);
   localparam logic [SAMPLE_BITS-1:0] THRESH_6 = SAMPLE_BITS'(3600);
   localparam logic [SAMPLE_BITS-1:0] THRESH_7 = SAMPLE_BITS'(3900);

   typedef struct packed {
      action_type             action;
      logic [SAMPLE_BITS-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] raw_level;
      logic [SAMPLE_BITS-1:0] filtered_level;
      logic [LEVEL_BITS-1:0]  step_percent;
      logic [LEVEL_BITS-1:0]  stable_percent;
   } rsp_type;

   typedef struct packed {
      logic                   started;
      logic [SAMPLE_BITS-1:0] last_raw;
      logic [SAMPLE_BITS-1:0] smoothed;
      logic [LEVEL_BITS-1:0]  candidate_level;
      logic [LEVEL_BITS-1:0]  settled_level;
      logic [COUNT_BITS-1:0]  agree_count;
   } state_type;

   function automatic logic [LEVEL_BITS-1:0] step_of(input logic [SAMPLE_BITS-1:0] v);
      logic [LEVEL_BITS-1:0] lvl;
      if (v <= THRESH_0)      lvl = LEVEL_BITS'(5);
      else if (v <= THRESH_1) lvl = LEVEL_BITS'(10);
      else if (v <= THRESH_2) lvl = LEVEL_BITS'(20);
      else if (v <= THRESH_3) lvl = LEVEL_BITS'(35);
      else if (v <= THRESH_4) lvl = LEVEL_BITS'(50);
      else if (v <= THRESH_5) lvl = LEVEL_BITS'(65);
      else if (v <= THRESH_6) lvl = LEVEL_BITS'(80);
      else if (v <= THRESH_7) lvl = LEVEL_BITS'(90);
      else                    lvl = LEVEL_BITS'(100);
      return lvl;
   endfunction

endpackage

// File: hw/rtl/light_level_stabilizer.sv
// Light level stabilizer: one sample per cycle while results are taken, filtered, mapped and debounced.
// Latency: the result of an item is valid in the cycle after its transfer.
// Throughput: one item per cycle while results are taken; the filter, step map and debounce are one
// combinational pass between the state registers and the result register.
// Reset clears all state, empties the result register and loads stable_count with 3.
`timescale 1ns / 1ps

module light_level_stabilizer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  lls_pkg::req_type               req,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output lls_pkg::rsp_type               rsp,
   input  logic                           csr_we,
   input  logic [lls_pkg::COUNT_BITS-1:0] csr_wdata
);

   logic [lls_pkg::COUNT_BITS-1:0] stable_count_ff;
   lls_pkg::state_type             state_ff;
   lls_pkg::state_type             state_in;
   logic                           rsp_valid_ff;
   lls_pkg::rsp_type               rsp_ff;
   logic                           accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   lls_update u_update (
      .state_cur    (state_ff),
      .req_item     (req),
      .stable_count (stable_count_ff),
      .state_nxt    (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_count_ff <= lls_pkg::STABLE_COUNT_RESET;
      end else if (csr_we) begin
         stable_count_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload of the result register, loaded on every transfer in
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff.raw_level      <= state_in.last_raw;
         rsp_ff.filtered_level <= state_in.smoothed;
         rsp_ff.step_percent   <= state_in.candidate_level;
         rsp_ff.stable_percent <= state_in.settled_level;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

`ifndef SYNTH
   a_update_before_init_ignored: assert property (@(posedge clock) disable iff (reset)
      (accept && req.action == lls_pkg::ACTION_UPDATE && !state_ff.started)
      |=> $stable(state_ff))
      else $error("update before initialize changed state");

   a_init_settles: assert property (@(posedge clock) disable iff (reset)
      (accept && req.action == lls_pkg::ACTION_INIT)
      |=> (state_ff.started && state_ff.settled_level == state_ff.candidate_level))
      else $error("initialize did not load a settled level");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      !state_ff.started |-> (state_ff.settled_level == '0 && state_ff.smoothed == '0))
      else $error("state moved before initialize");

   a_result_tracks_state: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_valid_ff && rsp_ff.filtered_level == state_ff.smoothed
                  && rsp_ff.stable_percent == state_ff.settled_level))
      else $error("result register out of step with state");
`endif

endmodule

// File: hw/rtl/lls_update.sv
// Next-state logic: low-pass filter, step map and persistence debounce for one sample.
`timescale 1ns / 1ps

module lls_update (
   input  lls_pkg::state_type                  state_cur,
   input  lls_pkg::req_type                    req_item,
   input  logic [lls_pkg::COUNT_BITS-1:0]      stable_count,
   output lls_pkg::state_type                  state_nxt
);

   logic [lls_pkg::ACC_BITS-1:0]    acc;
   logic [lls_pkg::SAMPLE_BITS-1:0] filt;
   logic [lls_pkg::LEVEL_BITS-1:0]  filt_lvl;
   logic [lls_pkg::LEVEL_BITS-1:0]  init_lvl;
   logic [lls_pkg::COUNT_BITS-1:0]  agree;

   // 7*filtered + sample, as 8*filtered - filtered + sample
   assign acc = ({state_cur.smoothed, 3'b000} - lls_pkg::ACC_BITS'(state_cur.smoothed))
              + lls_pkg::ACC_BITS'(req_item.sample);
   assign filt     = acc[lls_pkg::ACC_BITS-1:3];
   assign filt_lvl = lls_pkg::step_of(filt);
   assign init_lvl = lls_pkg::step_of(req_item.sample);

   always_comb begin
      state_nxt = state_cur;
      agree     = state_cur.agree_count;
      if (req_item.action == lls_pkg::ACTION_INIT) begin
         state_nxt.started         = 1'b1;
         state_nxt.last_raw        = req_item.sample;
         state_nxt.smoothed        = req_item.sample;
         state_nxt.candidate_level = init_lvl;
         state_nxt.settled_level   = init_lvl;
         state_nxt.agree_count     = stable_count;
      end else if (state_cur.started) begin
         state_nxt.last_raw = req_item.sample;
         state_nxt.smoothed = filt;
         if (filt_lvl == state_cur.candidate_level) begin
            // count up, saturating at the threshold
            if (state_cur.agree_count < stable_count) begin
               agree = state_cur.agree_count + lls_pkg::COUNT_BITS'(1);
            end
         end else begin
            state_nxt.candidate_level = filt_lvl;
            agree = lls_pkg::COUNT_BITS'(1);
         end
         state_nxt.agree_count = agree;
         if (agree >= stable_count) begin
            state_nxt.settled_level = state_nxt.candidate_level;
         end
      end
   end

endmodule

// File: dv/light_level_checker.sv
// Checker for the light level stabilizer: predicts every result and compares it on transfer.
`timescale 1ns / 1ps

module light_level_checker
   import lls_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp,
   input  logic                  csr_we,
   input  logic [COUNT_BITS-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending_count
);

   rsp_type expected_rsps[$];

   logic [COUNT_BITS-1:0]  hold_count;
   logic                   begun;
   logic [SAMPLE_BITS-1:0] last_sample;
   logic [SAMPLE_BITS-1:0] smooth_value;
   logic [LEVEL_BITS-1:0]  cand_pct;
   logic [LEVEL_BITS-1:0]  settled_pct;
   logic [COUNT_BITS-1:0]  agree_run;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   function automatic logic [LEVEL_BITS-1:0] brightness_step(input logic [SAMPLE_BITS-1:0] v);
      int unsigned x;
      x = v;
      if (x > 3900) return LEVEL_BITS'(100);
      if (x > 3600) return LEVEL_BITS'(90);
      if (x > 3200) return LEVEL_BITS'(80);
      if (x > 2600) return LEVEL_BITS'(65);
      if (x > 1800) return LEVEL_BITS'(50);
      if (x > 1000) return LEVEL_BITS'(35);
      if (x > 500)  return LEVEL_BITS'(20);
      if (x > 200)  return LEVEL_BITS'(10);
      return LEVEL_BITS'(5);
   endfunction

   function automatic rsp_type predict_light_level(input req_type item);
      logic [ACC_BITS-1:0]   acc;
      logic [LEVEL_BITS-1:0] pct;
      rsp_type               r;
      if (item.action == ACTION_INIT) begin
         pct          = brightness_step(item.sample);
         begun        = 1'b1;
         last_sample  = item.sample;
         smooth_value = item.sample;
         cand_pct     = pct;
         settled_pct  = pct;
         agree_run    = hold_count;
      end else if (begun) begin
         last_sample  = item.sample;
         acc          = ACC_BITS'(smooth_value) * ACC_BITS'(7) + ACC_BITS'(item.sample);
         smooth_value = acc[ACC_BITS-1:3];
         pct          = brightness_step(smooth_value);
         if (pct == cand_pct) begin
            // saturate at the required run length
            if (agree_run < hold_count) agree_run = agree_run + 1'b1;
         end else begin
            cand_pct  = pct;
            agree_run = COUNT_BITS'(1);
         end
         if (agree_run >= hold_count) settled_pct = cand_pct;
      end
      r.raw_level      = last_sample;
      r.filtered_level = smooth_value;
      r.step_percent   = cand_pct;
      r.stable_percent = settled_pct;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR %0t: %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         expected_rsps.delete();
         hold_count   = STABLE_COUNT_RESET;
         begun        = 1'b0;
         last_sample  = '0;
         smooth_value = '0;
         cand_pct     = '0;
         settled_pct  = '0;
         agree_run    = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("result transfer with nothing expected");
            end else begin
               want = expected_rsps.pop_front();
               check_field("raw_level", rsp.raw_level, want.raw_level);
               check_field("filtered_level", rsp.filtered_level, want.filtered_level);
               check_field("step_percent", rsp.step_percent, want.step_percent);
               check_field("stable_percent", rsp.stable_percent, want.stable_percent);
            end
         end
         if (req_valid && req_ready) expected_rsps.push_back(predict_light_level(req));
         if (csr_we) hold_count = csr_wdata;
      end
      pending_count = expected_rsps.size();
   end

endmodule

// File: dv/testbench.sv
// Top of the light level stabilizer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
   import lls_pkg::*;

   localparam int QUIET_LIMIT = 2000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp;
   logic                  csr_we;
   logic [COUNT_BITS-1:0] csr_wdata;

   int fail_count;
   int pending_count;
   int send_idle_pct;
   int recv_idle_pct;
   int quiet_cycles;

   light_level_stabilizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   light_level_checker level_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req           (req),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp           (rsp),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // end the run if nothing transfers for too long
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_item(input action_type act, input logic [SAMPLE_BITS-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req       <= req_type'{action: act, sample: value};
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // drain every expected result, then write the register while idle
   task automatic write_stable_count(input logic [COUNT_BITS-1:0] value);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (2) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin : stimulus
      int bounds[8];
      int seg_items[6];
      int seg_hold[6];
      int seg;
      int n;
      int run_left;
      int target;
      int value;
      int hold;

      bounds    = '{200, 500, 1000, 1800, 2600, 3200, 3600, 3900};
      seg_items = '{200, 200, 400, 200, 200, 250};
      seg_hold  = '{1, 0, 255, 2, 5, 0};
      seg_hold[5] = $urandom_range(1, 255);

      reset         = 1'b1;
      req_valid     = 1'b0;
      req           = '0;
      rsp_ready     = 1'b0;
      csr_we        = 1'b0;
      csr_wdata     = '0;
      send_idle_pct = 6;
      recv_idle_pct = 75;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // updates before any initialize must be ignored
      send_item(ACTION_UPDATE, 12'hFFF);
      send_item(ACTION_UPDATE, 12'h000);
      send_item(ACTION_INIT, 12'hFFF);
      send_item(ACTION_INIT, 12'h000);
      // climb from the bottom: step changes, then repeats toward the stable count
      repeat (4) send_item(ACTION_UPDATE, 12'hFFF);
      foreach (bounds[i]) begin
         send_item(ACTION_INIT, SAMPLE_BITS'(bounds[i]));
         send_item(ACTION_INIT, SAMPLE_BITS'(bounds[i] + 1));
      end

      run_left = 0;
      target   = 0;
      for (seg = 0; seg < 6; seg++) begin
         if (seg == 2) begin
            send_idle_pct = 75;
            recv_idle_pct = 6;
         end else if (seg == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         hold = seg_hold[seg];
         write_stable_count(COUNT_BITS'(hold));
         for (n = 0; n < seg_items[seg]; n++) begin
            if ($urandom_range(99) < 4) begin
               send_item(action_type'($urandom_range(1)), SAMPLE_BITS'($urandom_range(4095)));
            end else if (run_left == 0) begin
               // new steady stretch, near a threshold a quarter of the time
               if ($urandom_range(3) == 0) target = bounds[$urandom_range(7)];
               else target = $urandom_range(4095);
               run_left = $urandom_range(1, 2 * hold + 12);
               if ($urandom_range(99) < 30) send_item(ACTION_INIT, SAMPLE_BITS'(target));
               else send_item(ACTION_UPDATE, SAMPLE_BITS'(target));
            end else begin
               value = target + $urandom_range(32) - 16;
               if (value < 0) value = 0;
               if (value > 4095) value = 4095;
               send_item(ACTION_UPDATE, SAMPLE_BITS'(value));
               run_left--;
            end
         end
      end

      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
